@@ hdl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and codes for the JSON string unescaper
// Result kinds, error codes, parser modes and the job record that travels
// from the parser front end through the job queue to the UTF-8 emitter.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NO_QUOTE   = 3'd0,
      ERR_CONTROL    = 3'd1,
      ERR_BAD_ESCAPE = 3'd2,
      ERR_BAD_HEX    = 3'd3,
      ERR_NO_LOW_ESC = 3'd4,
      ERR_BAD_LOW    = 3'd5,
      ERR_LONE_LOW   = 3'd6
   } error_type;

   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_STRING  = 7'b0000010,
      MODE_ESCAPE  = 7'b0000100,
      MODE_HEX_HI  = 7'b0001000,
      MODE_WANT_BS = 7'b0010000,
      MODE_WANT_U  = 7'b0100000,
      MODE_HEX_LO  = 7'b1000000
   } mode_type;

   localparam int CP_WIDTH        = 21;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // is_cp set: data is a code point to be UTF-8 encoded; else data[7:0] goes out as is
   typedef struct packed {
      kind_type              kind;
      error_type             error_code;
      logic                  is_cp;
      logic [CP_WIDTH-1:0]   data;
   } job_type;

endpackage

@@ hdl/jsu_channels.sv @@
// ----------------------------------------------------------------------------
// jsu_channels: request and response channels
// Valid/ready channels carrying one input byte and one result record.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output kind, output out_byte, output error_code,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input error_code,
                   input last, output ready);
endinterface

@@ hdl/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front: JSON string parser front end
// Accepts one byte per cycle while the job queue is not full, tracks the parse
// mode, escapes and hex digits, and pushes at most one job per byte into the job queue.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              queue_full,
   output logic              push,
   output jsu_pkg::job_type  job
);

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [15:0]       acc_ff, acc_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [9:0]        hi_ff, hi_in;

   logic              accept;
   logic              hex_ok;
   logic [3:0]        hex_val;
   logic [15:0]       acc_next;
   logic [7:0]        c;

   assign c         = req_in_byte;
   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign acc_next  = {acc_ff[11:0], hex_val};

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = c[3:0];
      if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_val = c[3:0] + 4'd9;
      end else if (!(c inside {[8'h30:8'h39]})) begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      push    = 1'b0;
      job     = '{kind: jsu_pkg::KIND_BYTE, error_code: jsu_pkg::ERR_NO_QUOTE,
                  is_cp: 1'b0, data: '0};

      case (mode_ff)
         jsu_pkg::MODE_IDLE: begin
            if (c == CHAR_QUOTE) begin
               mode_in = jsu_pkg::MODE_STRING;
            end else if (!(c inside {[8'h09:8'h0D], CHAR_SPACE})) begin
               push           = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_NO_QUOTE;
            end
         end
         jsu_pkg::MODE_STRING: begin
            if (c == CHAR_QUOTE) begin
               mode_in  = jsu_pkg::MODE_IDLE;
               push     = 1'b1;
               job.kind = jsu_pkg::KIND_END;
            end else if (c inside {[8'h00:8'h1F], CHAR_DEL}) begin
               push           = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_CONTROL;
            end else if (c == CHAR_BACKSLASH) begin
               mode_in = jsu_pkg::MODE_ESCAPE;
            end else begin
               push     = 1'b1;
               job.data = {{(jsu_pkg::CP_WIDTH-8){1'b0}}, c};
            end
         end
         jsu_pkg::MODE_ESCAPE: begin
            mode_in = jsu_pkg::MODE_STRING;
            push    = 1'b1;
            case (c)
               CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH:
                  job.data = {{(jsu_pkg::CP_WIDTH-8){1'b0}}, c};
               CHAR_B: job.data = jsu_pkg::CP_WIDTH'(8'h08);
               CHAR_F: job.data = jsu_pkg::CP_WIDTH'(8'h0C);
               CHAR_N: job.data = jsu_pkg::CP_WIDTH'(8'h0A);
               CHAR_R: job.data = jsu_pkg::CP_WIDTH'(8'h0D);
               CHAR_T: job.data = jsu_pkg::CP_WIDTH'(8'h09);
               CHAR_U: begin
                  mode_in = jsu_pkg::MODE_HEX_HI;
                  push    = 1'b0;
                  acc_in  = '0;
                  cnt_in  = '0;
               end
               default: begin
                  job.kind       = jsu_pkg::KIND_ERROR;
                  job.error_code = jsu_pkg::ERR_BAD_ESCAPE;
               end
            endcase
         end
         jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
            if (!hex_ok) begin
               push           = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_BAD_HEX;
            end else if (cnt_ff != 2'd3) begin
               acc_in = acc_next;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               if (mode_ff == jsu_pkg::MODE_HEX_HI) begin
                  if (acc_next inside {[16'hD800:16'hDBFF]}) begin
                     hi_in   = acc_next[9:0];
                     mode_in = jsu_pkg::MODE_WANT_BS;
                  end else if (acc_next inside {[16'hDC00:16'hDFFF]}) begin
                     push           = 1'b1;
                     job.kind       = jsu_pkg::KIND_ERROR;
                     job.error_code = jsu_pkg::ERR_LONE_LOW;
                  end else begin
                     mode_in   = jsu_pkg::MODE_STRING;
                     push      = 1'b1;
                     job.is_cp = 1'b1;
                     job.data  = {{(jsu_pkg::CP_WIDTH-16){1'b0}}, acc_next};
                  end
               end else if (!(acc_next inside {[16'hDC00:16'hDFFF]})) begin
                  push           = 1'b1;
                  job.kind       = jsu_pkg::KIND_ERROR;
                  job.error_code = jsu_pkg::ERR_BAD_LOW;
               end else begin
                  mode_in   = jsu_pkg::MODE_STRING;
                  hi_in     = '0;
                  push      = 1'b1;
                  job.is_cp = 1'b1;
                  job.data  = {1'b0, hi_ff, acc_next[9:0]} + 21'h10000;
               end
            end
         end
         jsu_pkg::MODE_WANT_BS: begin
            if (c == CHAR_BACKSLASH) begin
               mode_in = jsu_pkg::MODE_WANT_U;
            end else begin
               push           = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_NO_LOW_ESC;
            end
         end
         jsu_pkg::MODE_WANT_U: begin
            if (c == CHAR_U) begin
               mode_in = jsu_pkg::MODE_HEX_LO;
               acc_in  = '0;
               cnt_in  = '0;
            end else begin
               push           = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_NO_LOW_ESC;
            end
         end
         default: begin
            push           = 1'b1;
            job.kind       = jsu_pkg::KIND_ERROR;
            job.error_code = jsu_pkg::ERR_NO_QUOTE;
         end
      endcase

      // any error drops back to idle with counters cleared
      if (job.kind == jsu_pkg::KIND_ERROR) begin
         mode_in = jsu_pkg::MODE_IDLE;
         acc_in  = '0;
         cnt_in  = '0;
         hi_in   = '0;
      end

      if (!accept) begin
         mode_in = mode_ff;
         acc_in  = acc_ff;
         cnt_in  = cnt_ff;
         hi_in   = hi_ff;
         push    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_IDLE;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         hi_ff   <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         hi_ff   <= hi_in;
      end
   end

endmodule

@@ hdl/jsu_queue.sv @@
// ----------------------------------------------------------------------------
// jsu_queue: job queue
// Small FIFO of parsed jobs between the parser and the UTF-8 emitter.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsu_pkg::job_type  job_in,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output jsu_pkg::job_type  head
);

   jsu_pkg::job_type                     slot_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_PTR_WIDTH-1:0]  wr_ff, wr_in;
   logic [jsu_pkg::QUEUE_PTR_WIDTH-1:0]  rd_ff, rd_in;
   logic [jsu_pkg::QUEUE_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                                 do_push, do_pop;

   assign full    = (cnt_ff == jsu_pkg::QUEUE_CNT_WIDTH'(jsu_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + jsu_pkg::QUEUE_PTR_WIDTH'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + jsu_pkg::QUEUE_PTR_WIDTH'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + jsu_pkg::QUEUE_CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - jsu_pkg::QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back: result emitter
// Takes the job at the queue head and sends its results one per cycle while
// the response side is ready, splitting code points into one to four UTF-8 bytes.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  jsu_pkg::job_type  head,
   output logic              pop,
   jsu_rsp_if.source         rsp_chan
);

   logic [1:0]                   idx_ff, idx_in;
   logic [1:0]                   last_idx;
   logic [7:0]                   byte_out;
   logic [jsu_pkg::CP_WIDTH-1:0] cp;
   logic                         fire;
   logic                         is_last;

   assign cp = head.data;

   always_comb begin
      last_idx = 2'd0;
      if (head.is_cp) begin
         if (cp < 21'h80) begin
            last_idx = 2'd0;
         end else if (cp < 21'h800) begin
            last_idx = 2'd1;
         end else if (cp < 21'h10000) begin
            last_idx = 2'd2;
         end else begin
            last_idx = 2'd3;
         end
      end
   end

   always_comb begin
      byte_out = cp[7:0];
      case (last_idx)
         2'd1: begin
            case (idx_ff)
               2'd0:    byte_out = {3'b110, cp[10:6]};
               default: byte_out = {2'b10, cp[5:0]};
            endcase
         end
         2'd2: begin
            case (idx_ff)
               2'd0:    byte_out = {4'b1110, cp[15:12]};
               2'd1:    byte_out = {2'b10, cp[11:6]};
               default: byte_out = {2'b10, cp[5:0]};
            endcase
         end
         2'd3: begin
            case (idx_ff)
               2'd0:    byte_out = {5'b11110, cp[20:18]};
               2'd1:    byte_out = {2'b10, cp[17:12]};
               2'd2:    byte_out = {2'b10, cp[11:6]};
               default: byte_out = {2'b10, cp[5:0]};
            endcase
         end
         default: byte_out = cp[7:0];
      endcase
   end

   assign is_last             = (idx_ff == last_idx);
   assign fire                = !empty && rsp_chan.ready;
   assign pop                 = fire && is_last;
   assign rsp_chan.valid      = !empty;
   assign rsp_chan.kind       = head.kind;
   assign rsp_chan.out_byte   = byte_out;
   assign rsp_chan.error_code = head.error_code;
   assign rsp_chan.last       = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ hdl/json_string_unescape_utf8_core.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core: JSON string unescaper with UTF-8 output
// Takes one byte of JSON text per request and returns decoded bytes, end of
// string markers and error codes. The parser takes a byte every cycle while
// its four-entry job queue has room; the emitter sends one result per cycle
// while the response side is ready. A \u escape, six or twelve bytes in,
// gives one to four results.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
   input  logic       clock,
   input  logic       reset,
   jsu_req_if.sink    req_chan,
   jsu_rsp_if.source  rsp_chan
);

   logic             push;
   logic             pop;
   logic             full;
   logic             empty;
   jsu_pkg::job_type job;
   jsu_pkg::job_type head;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_in_byte (req_chan.in_byte),
      .queue_full  (full),
      .push        (push),
      .job         (job)
   );

   jsu_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (job),
      .pop    (pop),
      .full   (full),
      .empty  (empty),
      .head   (head)
   );

   jsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ tb/sv/jsu_unescape_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_unescape_checker: result checker for the JSON string unescaper
// Watches both channels. Every accepted request byte runs through a local
// model of the string parser, and the decoded bytes, end markers and error
// codes it yields are queued. Every accepted response is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module jsu_unescape_checker (
   input  logic clock,
   input  logic reset,
   jsu_req_if   req_chan,
   jsu_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      jsu_pkg::kind_type  kind;
      logic [7:0]         out_byte;
      jsu_pkg::error_type error_code;
      logic               last;
   } decoded_type;

   jsu_pkg::mode_type parse_mode;
   logic [15:0]       hex_acc;
   logic [1:0]        hex_cnt;
   logic [9:0]        high_bits;

   decoded_type decoded_q[$];
   decoded_type step_out[$];
   decoded_type head;
   int          errors;

   function automatic int hex_digit(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   task automatic add_result(jsu_pkg::kind_type k, logic [7:0] value,
                             jsu_pkg::error_type code);
      decoded_type r;
      r.kind       = k;
      r.out_byte   = value;
      r.error_code = code;
      r.last       = 1'b0;
      step_out.insert(step_out.size(), r);
   endtask

   task automatic add_byte(logic [7:0] b);
      add_result(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NO_QUOTE);
   endtask

   // drop back to idle and clear the counters
   task automatic add_error(jsu_pkg::error_type code);
      add_result(jsu_pkg::KIND_ERROR, 8'h00, code);
      parse_mode = jsu_pkg::MODE_IDLE;
      hex_acc    = 16'h0000;
      hex_cnt    = 2'd0;
      high_bits  = 10'd0;
   endtask

   task automatic add_code_point(logic [20:0] cp);
      if (cp < 21'h00080) begin
         add_byte(cp[7:0]);
      end else if (cp < 21'h00800) begin
         add_byte({3'b110, cp[10:6]});
         add_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         add_byte({4'b1110, cp[15:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end else begin
         add_byte({5'b11110, cp[20:18]});
         add_byte({2'b10, cp[17:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end
   endtask

   task automatic decode_byte(logic [7:0] c);
      int          h;
      logic [15:0] code16;
      logic [20:0] cp;
      step_out.delete();
      case (parse_mode)
         jsu_pkg::MODE_IDLE: begin
            if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20) begin
            end else if (c == 8'h22) begin
               parse_mode = jsu_pkg::MODE_STRING;
            end else begin
               add_error(jsu_pkg::ERR_NO_QUOTE);
            end
         end
         jsu_pkg::MODE_STRING: begin
            if (c == 8'h22) begin
               parse_mode = jsu_pkg::MODE_IDLE;
               add_result(jsu_pkg::KIND_END, 8'h00, jsu_pkg::ERR_NO_QUOTE);
            end else if (c <= 8'h1F || c == 8'h7F) begin
               add_error(jsu_pkg::ERR_CONTROL);
            end else if (c == 8'h5C) begin
               parse_mode = jsu_pkg::MODE_ESCAPE;
            end else begin
               add_byte(c);
            end
         end
         jsu_pkg::MODE_ESCAPE: begin
            parse_mode = jsu_pkg::MODE_STRING;
            case (c)
               8'h22, 8'h5C, 8'h2F: add_byte(c);
               8'h62: add_byte(8'h08);
               8'h66: add_byte(8'h0C);
               8'h6E: add_byte(8'h0A);
               8'h72: add_byte(8'h0D);
               8'h74: add_byte(8'h09);
               8'h75: begin
                  parse_mode = jsu_pkg::MODE_HEX_HI;
                  hex_acc    = 16'h0000;
                  hex_cnt    = 2'd0;
               end
               default: add_error(jsu_pkg::ERR_BAD_ESCAPE);
            endcase
         end
         jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
            h = hex_digit(c);
            if (h < 0) begin
               add_error(jsu_pkg::ERR_BAD_HEX);
            end else begin
               hex_acc = {hex_acc[11:0], h[3:0]};
               if (hex_cnt != 2'd3) begin
                  hex_cnt = hex_cnt + 2'd1;
               end else begin
                  hex_cnt = 2'd0;
                  code16  = hex_acc;
                  hex_acc = 16'h0000;
                  if (parse_mode == jsu_pkg::MODE_HEX_HI) begin
                     if (code16 >= 16'hD800 && code16 <= 16'hDBFF) begin
                        high_bits  = code16[9:0];
                        parse_mode = jsu_pkg::MODE_WANT_BS;
                     end else if (code16 >= 16'hDC00 && code16 <= 16'hDFFF) begin
                        add_error(jsu_pkg::ERR_LONE_LOW);
                     end else begin
                        parse_mode = jsu_pkg::MODE_STRING;
                        add_code_point({5'd0, code16});
                     end
                  end else if (code16 < 16'hDC00 || code16 > 16'hDFFF) begin
                     add_error(jsu_pkg::ERR_BAD_LOW);
                  end else begin
                     cp         = {1'b0, high_bits, code16[9:0]} + 21'h10000;
                     high_bits  = 10'd0;
                     parse_mode = jsu_pkg::MODE_STRING;
                     add_code_point(cp);
                  end
               end
            end
         end
         jsu_pkg::MODE_WANT_BS: begin
            if (c == 8'h5C) parse_mode = jsu_pkg::MODE_WANT_U;
            else add_error(jsu_pkg::ERR_NO_LOW_ESC);
         end
         jsu_pkg::MODE_WANT_U: begin
            if (c == 8'h75) begin
               parse_mode = jsu_pkg::MODE_HEX_LO;
               hex_acc    = 16'h0000;
               hex_cnt    = 2'd0;
            end else begin
               add_error(jsu_pkg::ERR_NO_LOW_ESC);
            end
         end
         default: add_error(jsu_pkg::ERR_NO_QUOTE);
      endcase
      if (step_out.size() > 0) begin
         step_out[step_out.size() - 1].last = 1'b1;
         foreach (step_out[i]) decoded_q.insert(decoded_q.size(), step_out[i]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         parse_mode = jsu_pkg::MODE_IDLE;
         hex_acc    = 16'h0000;
         hex_cnt    = 2'd0;
         high_bits  = 10'd0;
         decoded_q.delete();
      end else begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) decode_byte(req_chan.in_byte);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected result: kind %0d out_byte 0x%02h error_code %0d last %0d",
                      rsp_chan.kind, rsp_chan.out_byte, rsp_chan.error_code, rsp_chan.last);
               errors++;
            end else begin
               head = decoded_q.pop_front();
               if (rsp_chan.kind !== head.kind) begin
                  $error("kind: expected %0d, got %0d", head.kind, rsp_chan.kind);
                  errors++;
               end
               if (rsp_chan.out_byte !== head.out_byte) begin
                  $error("out_byte: expected 0x%02h, got 0x%02h", head.out_byte,
                         rsp_chan.out_byte);
                  errors++;
               end
               if (rsp_chan.error_code !== head.error_code) begin
                  $error("error_code: expected %0d, got %0d", head.error_code,
                         rsp_chan.error_code);
                  errors++;
               end
               if (rsp_chan.last !== head.last) begin
                  $error("last: expected %0d, got %0d", head.last, rsp_chan.last);
                  errors++;
               end
            end
         end
      end
      pending    <= decoded_q.size();
      fail_count <= errors;
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the JSON string unescaper
// Feeds a byte stream of directed strings followed by random well-formed
// strings with escapes, \u code points and surrogate pairs, mixed with
// broken sequences that hit every error. Requests go out in bursts, the
// response side stalls on changing patterns and once holds off long enough
// to back up the block. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

   localparam int STIM_BYTES     = 230;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   sent_count = 0;
   bit   holding_off = 1'b0;

   logic [7:0] stim_q[$];

   jsu_req_if req_chan ();
   jsu_rsp_if rsp_chan ();

   json_string_unescape_utf8_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   jsu_unescape_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic stim_add(logic [7:0] b);
      stim_q.insert(stim_q.size(), b);
   endtask

   function automatic logic [7:0] nibble_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'h0, n};
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
   endfunction

   function automatic logic [15:0] random_high();
      return 16'hD800 + 16'($urandom_range(0, 16'h03FF));
   endfunction

   function automatic logic [15:0] random_low();
      return 16'hDC00 + 16'($urandom_range(0, 16'h03FF));
   endfunction

   task automatic push_u_escape(logic [15:0] v);
      stim_add(8'h5C);
      stim_add(8'h75);
      stim_add(nibble_char(v[15:12]));
      stim_add(nibble_char(v[11:8]));
      stim_add(nibble_char(v[7:4]));
      stim_add(nibble_char(v[3:0]));
   endtask

   // optional whitespace, then the opening quote
   task automatic push_open();
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 1)) stim_add(8'h20);
         else stim_add(8'($urandom_range(8'h09, 8'h0D)));
      end
      stim_add(8'h22);
   endtask

   task automatic push_element();
      int          sel;
      logic [7:0]  b;
      logic [15:0] v;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         if ($urandom_range(0, 3) == 0) begin
            b = 8'($urandom_range(8'h80, 8'hFF));
         end else begin
            do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == 8'h22 || b == 8'h5C);
         end
         stim_add(b);
      end else if (sel < 6) begin
         case ($urandom_range(0, 7))
            0: b = 8'h22;
            1: b = 8'h5C;
            2: b = 8'h2F;
            3: b = 8'h62;
            4: b = 8'h66;
            5: b = 8'h6E;
            6: b = 8'h72;
            default: b = 8'h74;
         endcase
         stim_add(8'h5C);
         stim_add(b);
      end else if (sel < 8) begin
         case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(16'h0000, 16'h007F));
            1: v = 16'($urandom_range(16'h0080, 16'h07FF));
            2: do v = 16'($urandom_range(16'h0800, 16'hFFFF));
               while (v >= 16'hD800 && v <= 16'hDFFF);
            default: v = 16'h0000;
         endcase
         push_u_escape(v);
      end else begin
         push_u_escape(random_high());
         push_u_escape(random_low());
      end
   endtask

   // watchdog: end the run when nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // response side: stall patterns plus one long hold-off
   initial begin
      int pattern;
      int span;
      bit hold_done;
      span      = 0;
      pattern   = 0;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count >= STIM_BYTES / 2) begin
            hold_done   = 1'b1;
            holding_off = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holding_off = 1'b0;
         end else begin
            if (span == 0) begin
               pattern = $urandom_range(0, 3);
               span    = $urandom_range(10, 40);
            end
            span--;
            case (pattern)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ~rsp_chan.ready;
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      int          burst;
      int          gap;
      logic [7:0]  b;
      logic [15:0] v;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;

      stim_add(8'h20);
      stim_add(8'h09);
      stim_add(8'h0D);
      stim_add(8'h00);
      stim_add(8'h22);
      stim_add(8'hFF);
      stim_add(8'h80);
      stim_add(8'h7F);
      stim_add(8'h22);
      push_u_escape(16'hFFFF);
      push_u_escape(16'hDBFF);
      push_u_escape(16'hDFFF);
      stim_add(8'h22);

      while (stim_q.size() < STIM_BYTES) begin
         push_open();
         if ($urandom_range(0, 99) < 65) begin
            repeat ($urandom_range(0, 4)) push_element();
            stim_add(8'h22);
         end else begin
            repeat ($urandom_range(0, 2)) push_element();
            case ($urandom_range(0, 8))
               0: begin
                  b = 8'($urandom_range(0, 32));
                  if (b == 8'd32) b = 8'h7F;
                  stim_add(b);
               end
               1: begin
                  do b = 8'($urandom_range(0, 255));
                  while (b inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74,
                                   8'h75});
                  stim_add(8'h5C);
                  stim_add(b);
               end
               2: begin
                  stim_add(8'h5C);
                  stim_add(8'h75);
                  repeat ($urandom_range(0, 3))
                     stim_add(nibble_char(4'($urandom_range(0, 15))));
                  do b = 8'($urandom_range(0, 255));
                  while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                         (b >= 8'h61 && b <= 8'h66));
                  stim_add(b);
               end
               3: begin
                  push_u_escape(random_high());
                  do b = 8'($urandom_range(0, 255)); while (b == 8'h5C);
                  stim_add(b);
               end
               4: begin
                  push_u_escape(random_high());
                  do b = 8'($urandom_range(0, 255)); while (b == 8'h75);
                  stim_add(8'h5C);
                  stim_add(b);
               end
               5: begin
                  push_u_escape(random_high());
                  do v = 16'($urandom_range(0, 16'hFFFF));
                  while (v >= 16'hDC00 && v <= 16'hDFFF);
                  push_u_escape(v);
               end
               6: push_u_escape(random_low());
               7: begin
                  stim_add(8'h22);
                  do b = 8'($urandom_range(0, 255));
                  while (b == 8'h22 || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
                  stim_add(b);
               end
               default: stim_add(8'($urandom_range(0, 255)));
            endcase
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      while (sent_count < stim_q.size()) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && sent_count < stim_q.size()) begin
            req_chan.valid   <= 1'b1;
            req_chan.in_byte <= stim_q[sent_count];
            @(posedge clock);
            while (!req_chan.ready) @(posedge clock);
            sent_count++;
            burst--;
            @(negedge clock);
         end
         gap = ($urandom_range(0, 3) == 0 || holding_off) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid   <= 1'b0;
            req_chan.in_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clock);
         end
      end
      req_chan.valid <= 1'b0;

      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
